@@ rtl/length_prefixed_frame_receiver_unit_defines.svh @@
// assertion macros for the length-prefixed frame receiver
// used by the port checker; no other dependencies
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define LPFR_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define LPFR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lpfr_pkg.sv @@
// shared types and codes for the length-prefixed frame receiver
// no dependencies
package lpfr_pkg;

   localparam logic [1:0] KIND_CONNECT = 2'd0;
   localparam logic [1:0] KIND_BYTE    = 2'd1;
   localparam logic [1:0] KIND_HANGUP  = 2'd2;
   localparam logic [1:0] KIND_LOCAL   = 2'd3;

   localparam logic [1:0] EV_PAYLOAD      = 2'd0;
   localparam logic [1:0] EV_CONNECTED    = 2'd1;
   localparam logic [1:0] EV_DISCONNECTED = 2'd2;
   localparam logic [1:0] EV_EMPTY        = 2'd3;

   localparam logic [1:0] MODE_DISCONNECTED = 2'd0;
   localparam logic [1:0] MODE_HEADER       = 2'd1;
   localparam logic [1:0] MODE_PAYLOAD      = 2'd2;

   localparam logic       REG_MAX_PAYLOAD = 1'b0;
   localparam logic       REG_MAGIC       = 1'b1;

   localparam logic [31:0] RESET_MAX_PAYLOAD = 32'd33554432;
   localparam logic [31:0] RESET_MAGIC       = 32'h3130_5456;

   localparam logic [2:0] HEADER_LAST_BYTE = 3'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] payload_byte;
      logic       last_of_message;
   } result_type;

endpackage

@@ rtl/lpfr_in_reg.sv @@
// input register for requests
// depends on lpfr_pkg
module lpfr_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lpfr_pkg::item_type req_item,
   input  logic               step,
   output logic               item_valid,
   output lpfr_pkg::item_type item
);
   import lpfr_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_tready = !valid_ff || step;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (step ? 1'b0 : valid_ff);
   assign item_in    = load ? req_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/lpfr_deframer.sv @@
// link state, header check and payload count, plus the two config registers
// depends on lpfr_pkg
module lpfr_deframer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 item_valid,
   input  lpfr_pkg::item_type   item,
   input  logic                 step,
   output logic                 res_valid,
   output lpfr_pkg::result_type res
);
   import lpfr_pkg::*;

   logic [31:0] max_len_ff, max_len_in;
   logic [31:0] magic_ff, magic_in;
   logic [1:0]  mode_ff, mode_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [63:0] hdr_shift_ff, hdr_shift_in;
   logic [31:0] left_ff, left_in;

   logic        connected;
   logic [63:0] shift_next;
   logic [31:0] left_dec;

   assign connected  = (mode_ff == MODE_HEADER) || (mode_ff == MODE_PAYLOAD);
   assign shift_next = {item.data_byte, hdr_shift_ff[63:8]};
   assign left_dec   = (left_ff != 32'd0) ? left_ff - 32'd1 : 32'd0;

   always_comb begin
      max_len_in = max_len_ff;
      magic_in   = magic_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_PAYLOAD: max_len_in = csr_data;
            REG_MAGIC:       magic_in   = csr_data;
            default:         max_len_in = max_len_ff;
         endcase
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_shift_in = hdr_shift_ff;
      left_in      = left_ff;
      res_valid    = 1'b0;
      res          = '0;
      case (item.kind)
         KIND_CONNECT: begin
            if (!connected) begin
               mode_in      = MODE_HEADER;
               hdr_cnt_in   = 3'd0;
               hdr_shift_in = 64'd0;
               left_in      = 32'd0;
               res_valid    = 1'b1;
               res.event_res = EV_CONNECTED;
            end
         end
         KIND_HANGUP: begin
            if (connected) begin
               mode_in      = MODE_DISCONNECTED;
               hdr_cnt_in   = 3'd0;
               hdr_shift_in = 64'd0;
               left_in      = 32'd0;
               res_valid    = 1'b1;
               res.event_res = EV_DISCONNECTED;
            end
         end
         KIND_LOCAL: begin
            mode_in      = MODE_DISCONNECTED;
            hdr_cnt_in   = 3'd0;
            hdr_shift_in = 64'd0;
            left_in      = 32'd0;
         end
         default: begin
            if (!connected) begin
               mode_in = MODE_DISCONNECTED;
            end else if (mode_ff == MODE_HEADER) begin
               hdr_shift_in = shift_next;
               hdr_cnt_in   = hdr_cnt_ff + 3'd1;
               if (hdr_cnt_ff == HEADER_LAST_BYTE) begin
                  hdr_cnt_in   = 3'd0;
                  hdr_shift_in = 64'd0;
                  left_in      = 32'd0;
                  if ((shift_next[31:0] > max_len_ff) ||
                      (shift_next[63:32] != magic_ff)) begin
                     mode_in       = MODE_DISCONNECTED;
                     res_valid     = 1'b1;
                     res.event_res = EV_DISCONNECTED;
                  end else if (shift_next[31:0] == 32'd0) begin
                     res_valid           = 1'b1;
                     res.event_res       = EV_EMPTY;
                     res.last_of_message = 1'b1;
                  end else begin
                     mode_in = MODE_PAYLOAD;
                     left_in = shift_next[31:0];
                  end
               end
            end else begin
               res_valid        = 1'b1;
               res.event_res    = EV_PAYLOAD;
               res.payload_byte = item.data_byte;
               left_in          = left_dec;
               if (left_dec == 32'd0) begin
                  mode_in             = MODE_HEADER;
                  hdr_cnt_in          = 3'd0;
                  hdr_shift_in        = 64'd0;
                  res.last_of_message = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= RESET_MAX_PAYLOAD;
         magic_ff     <= RESET_MAGIC;
         mode_ff      <= MODE_DISCONNECTED;
         hdr_cnt_ff   <= 3'd0;
         hdr_shift_ff <= 64'd0;
         left_ff      <= 32'd0;
      end else begin
         max_len_ff <= max_len_in;
         magic_ff   <= magic_in;
         if (item_valid && step) begin
            mode_ff      <= mode_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            hdr_shift_ff <= hdr_shift_in;
            left_ff      <= left_in;
         end
      end
   end

endmodule

@@ rtl/lpfr_out_reg.sv @@
// result register on the response side
// depends on lpfr_pkg
module lpfr_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  lpfr_pkg::result_type load_res,
   output logic                 load_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lpfr_pkg::result_type rsp_res
);
   import lpfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign load_ready = !valid_ff || rsp_tready;
   assign valid_in   = load_ready ? load_valid : valid_ff;
   assign res_in     = (load_ready && load_valid) ? load_res : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

@@ rtl/length_prefixed_frame_receiver_unit.sv @@
// length-prefixed frame receiver: input register, deframer, result register
// one request per cycle, and no gaps on rsp, while rsp_tready stays high; a request
// waits in the input register and its result in the result register before it shows
// on rsp; requests without a result leave no bubble; synchronous active-high reset
// returns the link to disconnected and the config registers to their default values
module length_prefixed_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // payload_byte
   output logic [1:0]  rsp_tuser,   // event_res
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import lpfr_pkg::*;

   item_type   req_item, item;
   logic       item_valid;
   logic       step;
   logic       res_valid;
   result_type res, rsp_res;
   logic       load_ready;

   assign req_item.kind      = req_tuser;
   assign req_item.data_byte = req_tdata;
   assign csr_ready          = 1'b1;
   assign step               = !res_valid || load_ready;

   lpfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   lpfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item       (item),
      .step       (step),
      .res_valid  (res_valid),
      .res        (res)
   );

   lpfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid && res_valid),
      .load_res   (res),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = rsp_res.payload_byte;
   assign rsp_tuser = rsp_res.event_res;
   assign rsp_tlast = rsp_res.last_of_message;

endmodule

@@ rtl/lpfr_checker.sv @@
// port-level checks for the length-prefixed frame receiver, bound to the top level
// depends on lpfr_pkg and length_prefixed_frame_receiver_unit_defines.svh
`include "length_prefixed_frame_receiver_unit_defines.svh"

module lpfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import lpfr_pkg::*;

   `LPFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "response changed while stalled")
   `LPFR_ASSERT_SAME(a_data_zero, clock, reset, rsp_tvalid && (rsp_tuser != EV_PAYLOAD), rsp_tdata == 8'd0, "nonzero data on event response")
   `LPFR_ASSERT_SAME(a_empty_last, clock, reset, rsp_tvalid && (rsp_tuser == EV_EMPTY), rsp_tlast, "empty message without last")
   `LPFR_ASSERT_SAME(a_link_no_last, clock, reset, rsp_tvalid && ((rsp_tuser == EV_CONNECTED) || (rsp_tuser == EV_DISCONNECTED)), !rsp_tlast, "link event marked last")

endmodule

bind length_prefixed_frame_receiver_unit lpfr_checker u_lpfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ verif/length_prefixed_frame_receiver_unit_tb.sv @@
// self-checking testbench for length_prefixed_frame_receiver_unit: streams link events and
// framed bytes, predicts every response with its own deframer model and checks them in order
// depends on lpfr_pkg and the unit under test
module length_prefixed_frame_receiver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpfr_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_CONNECT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = REG_MAX_PAYLOAD;
   logic [31:0] csr_data   = '0;

   logic [1:0]  link_mode    = MODE_DISCONNECTED;
   logic [2:0]  hdr_count    = '0;
   logic [63:0] hdr_shift    = '0;
   logic [31:0] payload_left = '0;
   logic [31:0] cfg_max_len  = RESET_MAX_PAYLOAD;
   logic [31:0] cfg_magic    = RESET_MAGIC;

   item_type   pending_reqs[$];
   result_type expected_results[$];
   item_type   req_cur;
   logic       gen_link_up = 1'b0;

   int gen_count;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;
   int cycle_count;
   int accepted_count;
   int rsp_count;
   int input_stalls;
   int mismatch_count;
   int by_event[4];

   length_prefixed_frame_receiver_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void expect_result(logic [1:0] ev, logic [7:0] data, logic last);
      expected_results.push_back('{event_res: ev, payload_byte: data, last_of_message: last});
   endfunction

   function automatic void clear_framing();
      hdr_count    = '0;
      hdr_shift    = '0;
      payload_left = '0;
   endfunction

   function automatic void deframe_step(item_type it);
      logic        connected;
      logic [31:0] len;
      logic [31:0] magic;
      connected = (link_mode == MODE_HEADER) || (link_mode == MODE_PAYLOAD);
      case (it.kind)
         KIND_CONNECT: begin
            if (!connected) begin
               clear_framing();
               link_mode = MODE_HEADER;
               expect_result(EV_CONNECTED, 8'h00, 1'b0);
            end
         end
         KIND_HANGUP: begin
            if (connected) begin
               link_mode = MODE_DISCONNECTED;
               clear_framing();
               expect_result(EV_DISCONNECTED, 8'h00, 1'b0);
            end
         end
         KIND_LOCAL: begin
            link_mode = MODE_DISCONNECTED;
            clear_framing();
         end
         KIND_BYTE: begin
            if (!connected) begin
               link_mode = MODE_DISCONNECTED;
            end else if (link_mode == MODE_HEADER) begin
               hdr_shift = {it.data_byte, hdr_shift[63:8]};
               hdr_count = hdr_count + 3'd1;
               if (hdr_count == 3'd0) begin
                  len   = hdr_shift[31:0];
                  magic = hdr_shift[63:32];
                  clear_framing();
                  if (len > cfg_max_len || magic != cfg_magic) begin
                     link_mode = MODE_DISCONNECTED;
                     expect_result(EV_DISCONNECTED, 8'h00, 1'b0);
                  end else if (len == 32'd0) begin
                     expect_result(EV_EMPTY, 8'h00, 1'b1);
                  end else begin
                     link_mode    = MODE_PAYLOAD;
                     payload_left = len;
                  end
               end
            end else begin
               if (payload_left != 32'd0) payload_left = payload_left - 32'd1;
               if (payload_left == 32'd0) begin
                  link_mode = MODE_HEADER;
                  clear_framing();
                  expect_result(EV_PAYLOAD, it.data_byte, 1'b1);
               end else begin
                  expect_result(EV_PAYLOAD, it.data_byte, 1'b0);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_response();
      result_type want;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("cycle %0d: unexpected response event %0d byte %02h last %0d",
                     cycle_count, rsp_tuser, rsp_tdata, rsp_tlast);
         return;
      end
      want = expected_results.pop_front();
      rsp_count++;
      by_event[want.event_res]++;
      if (rsp_tuser != want.event_res || rsp_tdata != want.payload_byte ||
          rsp_tlast != want.last_of_message) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("cycle %0d: expected event %0d byte %02h last %0d, got %0d %02h %0d",
                     cycle_count, want.event_res, want.payload_byte, want.last_of_message,
                     rsp_tuser, rsp_tdata, rsp_tlast);
      end
   endfunction

   function automatic void push_item(logic [1:0] k, logic [7:0] data);
      pending_reqs.push_back('{kind: k, data_byte: data});
      gen_count++;
   endfunction

   function automatic void push_header_part(logic [31:0] len, logic [31:0] magic, int first,
                                            int count);
      logic [63:0] hdr;
      hdr = {magic, len};
      for (int i = first; i < first + count; i++) push_item(KIND_BYTE, hdr[8*i +: 8]);
   endfunction

   function automatic void push_payload(int n);
      repeat (n) push_item(KIND_BYTE, 8'($urandom_range(255)));
   endfunction

   function automatic logic [31:0] pick_len();
      int          r;
      logic [31:0] len;
      r = $urandom_range(99);
      if (r < 10) len = 32'd0;
      else if (r < 85) len = 32'($urandom_range(8, 1));
      else len = 32'($urandom_range(40, 9));
      if (len > cfg_max_len) len = cfg_max_len;
      return len;
   endfunction

   function automatic void push_good_frame();
      logic [31:0] len;
      int          split;
      len = pick_len();
      if ($urandom_range(99) < 5) begin
         // a connect inside a frame must leave the framing untouched
         split = $urandom_range(7, 1);
         push_header_part(len, cfg_magic, 0, split);
         push_item(KIND_CONNECT, 8'($urandom_range(255)));
         push_header_part(len, cfg_magic, split, 8 - split);
      end else begin
         push_header_part(len, cfg_magic, 0, 8);
      end
      push_payload(len);
   endfunction

   function automatic void push_random_burst();
      int          r;
      logic [31:0] len;
      r = $urandom_range(99);
      if (r >= 70 && r < 77 && cfg_max_len == 32'hFFFF_FFFF) r = 0;
      if (!gen_link_up) push_item(KIND_CONNECT, 8'($urandom_range(255)));
      gen_link_up = 1'b1;
      if (r < 62) begin
         repeat ($urandom_range(3, 1)) push_good_frame();
      end else if (r < 70) begin
         len = pick_len();
         if ($urandom_range(1))
            push_header_part(len, cfg_magic ^ (32'd1 << $urandom_range(31)), 0, 8);
         else
            push_header_part(len, $urandom(), 0, 8);
         gen_link_up = 1'b0;
      end else if (r < 77) begin
         if (cfg_max_len > 32'hFFFF_FFF0) len = 32'hFFFF_FFFF;
         else len = cfg_max_len + 32'd1 + 32'($urandom_range(3));
         push_header_part(len, cfg_magic, 0, 8);
         gen_link_up = 1'b0;
      end else if (r < 85) begin
         len = pick_len();
         if (len == 32'd0 || $urandom_range(2) == 0) begin
            push_header_part(len, cfg_magic, 0, $urandom_range(7, 1));
         end else begin
            push_header_part(len, cfg_magic, 0, 8);
            push_payload($urandom_range(len - 32'd1));
         end
         push_item($urandom_range(1) ? KIND_HANGUP : KIND_LOCAL, 8'($urandom_range(255)));
         gen_link_up = 1'b0;
      end else if (r < 92) begin
         push_item($urandom_range(1) ? KIND_HANGUP : KIND_LOCAL, 8'($urandom_range(255)));
         repeat ($urandom_range(3))
            push_item($urandom_range(1) ? KIND_BYTE : KIND_HANGUP, 8'($urandom_range(255)));
         gen_link_up = 1'b0;
      end else begin
         repeat ($urandom_range(4, 1)) push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
         push_item(KIND_LOCAL, 8'($urandom_range(255)));
         gen_link_up = 1'b0;
      end
   endfunction

   function automatic void push_random_until(int target);
      while (gen_count < target) push_random_burst();
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MAX_PAYLOAD) cfg_max_len = value;
      else cfg_magic = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (req_tvalid && req_tready) begin
            deframe_step(req_cur);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_cur = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= req_cur.data_byte;
               req_tuser  <= req_cur.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("length_prefixed_frame_receiver_unit_tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 31;
      recv_idle_pct = 73;

      // idle link events, reconnect, short frame, empty message, oversize header
      push_item(KIND_BYTE, 8'hFF);
      push_item(KIND_HANGUP, 8'hFF);
      push_item(KIND_LOCAL, 8'h00);
      push_item(KIND_CONNECT, 8'h00);
      push_item(KIND_CONNECT, 8'hFF);
      push_header_part(32'd2, cfg_magic, 0, 8);
      push_item(KIND_BYTE, 8'h00);
      push_item(KIND_BYTE, 8'hFF);
      push_header_part(32'd0, cfg_magic, 0, 8);
      push_header_part(cfg_max_len + 32'd1, cfg_magic, 0, 8);
      wait_drained();

      write_csr(REG_MAX_PAYLOAD, 32'd16);
      write_csr(REG_MAGIC, $urandom());
      push_random_until(650);
      wait_drained();

      send_idle_pct = 73;
      recv_idle_pct = 31;
      write_csr(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
      write_csr(REG_MAGIC, 32'hFFFF_FFFF);
      push_item(KIND_CONNECT, 8'h00);
      push_header_part(32'hFFFF_FFFF, cfg_magic, 0, 8);
      push_payload(3);
      push_item(KIND_HANGUP, 8'h00);
      wait_drained();

      // long frame against a blocked response side
      send_idle_pct = 0;
      stall_left    = STALL_CYCLES;
      push_item(KIND_CONNECT, 8'h00);
      push_header_part(32'd100, cfg_magic, 0, 8);
      push_payload(100);
      gen_link_up = 1'b1;
      wait_drained();
      send_idle_pct = 73;
      push_random_until(1250);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_MAX_PAYLOAD, 32'd0);
      write_csr(REG_MAGIC, 32'd0);
      push_random_until(1450);
      wait_drained();

      write_csr(REG_MAX_PAYLOAD, 32'd40);
      write_csr(REG_MAGIC, RESET_MAGIC);
      push_random_until(1900);
      wait_drained();

      $display("sent %0d requests, checked %0d responses: %0d payload, %0d connect,",
               accepted_count, rsp_count, by_event[EV_PAYLOAD], by_event[EV_CONNECTED]);
      $display("%0d disconnect, %0d empty; input stalled %0d cycles, %0d mismatches",
               by_event[EV_DISCONNECTED], by_event[EV_EMPTY], input_stalls, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("length_prefixed_frame_receiver_unit_tb OK");
      end else begin
         $display("length_prefixed_frame_receiver_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
